// ----- sv/keyframe_linear_animator_macros.svh -----
// ---------------------------------------------------------------------------
// Keyframe linear animator assertion macros
// Shared assertion forms for the checker of the animator.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_ANIMATOR_MACROS_SVH
`define KEYFRAME_LINEAR_ANIMATOR_MACROS_SVH

// Checked only outside reset.
`define KLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KLA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/kla_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear animator package
// Widths, codes and shared types of the animator.
// ---------------------------------------------------------------------------
package kla_pkg;

    localparam int MAX_KEYS_DEF = 16;

    localparam int TIME_W   = 32;
    localparam int LEN_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int LOWER_W  = 4;
    localparam int DIV_W    = 34;
    localparam int DVD_W    = 33;
    localparam int STEP_W   = 6;
    localparam int WORD_W   = 2 * TIME_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SET    = 2'd1,
        CMD_ADD    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_ANIM_LENGTH = 1'b0,
        CFG_LOOP_ENABLE = 1'b1
    } t_cfg_idx;

    // Request to the shared divider: the partial remainder to start from,
    // the dividend bits shifted in MSB first, the divisor and the step count.
    typedef struct packed {
        logic [DIV_W-1:0]  rem0;
        logic [DVD_W-1:0]  dvd;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ----- sv/kla_key_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe table memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module kla_key_ram
    import kla_pkg::*;
#(
    parameter int DEPTH = MAX_KEYS_DEF,
    parameter int AW    = $clog2(MAX_KEYS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/kla_divider.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe animator divider
// Restoring division, one quotient bit per cycle, shared by the wrap,
// the key search reduction and the fraction.
// ---------------------------------------------------------------------------
module kla_divider
    import kla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_rem,
    output logic [FRAC_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_divisor;
    logic [FRAC_W-1:0] r_quo;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] trial_sub;
    logic           ge;

    assign trial     = {r_rem, r_dvd[DVD_W-1]};
    assign trial_sub = trial - {1'b0, r_divisor};
    assign ge        = trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_req.rem0;
            r_dvd     <= i_req.dvd;
            r_divisor <= i_req.divisor;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[FRAC_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

// ----- sv/keyframe_linear_animator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear animator
// Sorted keyframe table with a time position and linear interpolation.
// ---------------------------------------------------------------------------
// One item is handled at a time. An item visits keyframes in the table
// memory (insert shifts from the top down, the search walks up from the
// first key), and uses the shared one-bit-a-step divider when the position
// wraps or lies above the length and when the fraction is divided.
// A finished result waits in an output register.
// The user must give configuration only while the block is idle; the
// block itself does not enforce it.
// ---------------------------------------------------------------------------
module keyframe_linear_animator
    import kla_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [LEN_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic [TIME_W-1:0]   i_time_arg,
    input  logic [TIME_W-1:0]   i_key_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LEN_W-1:0]    o_time_now,
    output logic [TIME_W-1:0]   o_interp_value,
    output logic [FRAC_W-1:0]   o_fraction,
    output logic [LOWER_W-1:0]  o_lower_index,
    output logic [1:0]          o_status
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INS_RD   = 12'b0000_0000_0010,
        S_INS_CHK  = 12'b0000_0000_0100,
        S_MOVE_DIV = 12'b0000_0000_1000,
        S_PREP     = 12'b0000_0001_0000,
        S_RED_DIV  = 12'b0000_0010_0000,
        S_SRD      = 12'b0000_0100_0000,
        S_SCHK     = 12'b0000_1000_0000,
        S_FRAC     = 12'b0001_0000_0000,
        S_FDIV     = 12'b0010_0000_0000,
        S_MUL      = 12'b0100_0000_0000,
        S_OUT      = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [LEN_W-1:0]         r_len;
    logic                     r_loop;
    logic [CW-1:0]            r_count;
    logic [LEN_W-1:0]         r_pos;
    logic                     r_neg;
    logic signed [TIME_W-1:0] r_arg;
    logic signed [TIME_W-1:0] r_kval;
    logic [CW-1:0]            r_idx;
    logic [LEN_W-1:0]         r_t;
    logic signed [TIME_W-1:0] r_first_t, r_first_v;
    logic signed [TIME_W-1:0] r_prev_t, r_prev_v;
    logic signed [TIME_W-1:0] r_t1, r_v1, r_v2;
    logic signed [TIME_W:0]   r_t2;
    logic [AW-1:0]            r_lower;
    logic [FRAC_W-1:0]        r_frac;
    logic signed [TIME_W+FRAC_W+1:0] r_prod;
    t_status                  r_status;

    logic                     r_out_valid;
    logic [LEN_W-1:0]         r_o_time;
    logic [TIME_W-1:0]        r_o_value;
    logic [FRAC_W-1:0]        r_o_frac;
    logic [LOWER_W-1:0]       r_o_lower;
    t_status                  r_o_status;

    // Memory and divider hookup
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic              div_start, div_done;
    t_div_req          div_req;
    logic [DIV_W-1:0]  div_rem;
    logic [FRAC_W-1:0] div_quo;

    kla_key_ram #(
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kla_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_rem   (div_rem),
        .o_quo   (div_quo)
    );

    // Position update on acceptance
    logic                     in_fire;
    logic signed [TIME_W:0]   arg_s, pos_s, len_s, move_v;
    logic                     move_same, move_neg, is_full;
    logic [DVD_W-1:0]         move_mag;
    logic [LEN_W-1:0]         clamp_v;

    assign in_fire   = i_in_valid && o_in_ready;
    assign arg_s     = {i_time_arg[TIME_W-1], i_time_arg};
    assign pos_s     = {2'b00, r_pos};
    assign len_s     = {2'b00, r_len};
    assign move_v    = (t_cmd'(i_cmd) == CMD_ADD) ? pos_s + arg_s : arg_s;
    assign move_same = move_v == pos_s;
    assign move_neg  = move_v[TIME_W];
    assign move_mag  = move_neg ? DVD_W'(-move_v) : DVD_W'(move_v);
    assign clamp_v   = move_neg ? '0 : ((move_v > len_s) ? r_len : move_v[LEN_W-1:0]);
    assign is_full   = r_count >= CW'(MAX_KEYS);

    // Table walk
    logic signed [TIME_W-1:0] rd_t, rd_v, first_t_sel, first_v_sel;
    logic signed [TIME_W:0]   t_s, rd_t_s;
    logic [CW-1:0]            idx_m1, idx_p1;
    logic                     rd_lt, rd_last;

    assign rd_t        = ram_rdata[WORD_W-1:TIME_W];
    assign rd_v        = ram_rdata[TIME_W-1:0];
    assign first_t_sel = (r_idx == '0) ? rd_t : r_first_t;
    assign first_v_sel = (r_idx == '0) ? rd_v : r_first_v;
    assign t_s         = {2'b00, r_t};
    assign rd_t_s      = {rd_t[TIME_W-1], rd_t};
    assign idx_m1      = r_idx - 1'b1;
    assign idx_p1      = r_idx + 1'b1;
    assign rd_lt       = rd_t_s < t_s;
    assign rd_last     = idx_p1 == r_count;

    // Fraction and value
    logic signed [TIME_W+1:0] frac_m, frac_d, frac_n;
    logic                     frac_pos, frac_sat;
    logic signed [TIME_W:0]   diff_v;
    logic signed [TIME_W+2:0] sum_v;
    logic [TIME_W-1:0]        sat_v;
    logic [AW+LOWER_W-1:0]    lower_wide;

    // Span and offset from the lower key are both signed: a position before
    // the first key gives a negative offset and a zero fraction.
    assign frac_m   = {{2{r_t1[TIME_W-1]}}, r_t1};
    assign frac_d   = {r_t2[TIME_W], r_t2} - frac_m;
    assign frac_n   = $signed({3'b000, r_t}) - frac_m;
    assign frac_pos = (frac_d > 0) && (frac_n > 0);
    assign frac_sat = frac_n >= frac_d;
    assign diff_v   = {r_v2[TIME_W-1], r_v2} - {r_v1[TIME_W-1], r_v1};
    assign sum_v    = {{3{r_v1[TIME_W-1]}}, r_v1}
                    + {r_prod[TIME_W+FRAC_W+1], r_prod[TIME_W+FRAC_W+1:FRAC_W]};
    assign lower_wide = {{LOWER_W{1'b0}}, r_lower};

    always_comb begin
        if (sum_v > $signed({3'b000, {(TIME_W-1){1'b1}}})) begin
            sat_v = {1'b0, {(TIME_W-1){1'b1}}};
        end else if (sum_v < $signed({3'b111, 1'b1, {(TIME_W-1){1'b0}}})) begin
            sat_v = {1'b1, {(TIME_W-1){1'b0}}};
        end else begin
            sat_v = sum_v[TIME_W-1:0];
        end
    end

    // Control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = {r_arg, r_kval};
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];
        div_start = 1'b0;
        div_req   = '{rem0: '0, dvd: '0, divisor: DIV_W'(r_len), steps: STEP_W'(DVD_W)};
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_INSERT: n_state = is_full ? S_PREP : S_INS_RD;
                        CMD_SET, CMD_ADD: begin
                            if (!move_same && r_loop && r_len != '0) begin
                                div_start   = 1'b1;
                                div_req.dvd = move_mag;
                                n_state     = S_MOVE_DIV;
                            end else begin
                                n_state = S_PREP;
                            end
                        end
                        default: n_state = S_PREP;
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_PREP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_m1[AW-1:0];
                    n_state   = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                ram_we = 1'b1;
                if (rd_t > r_arg) begin
                    ram_wdata = ram_rdata;
                    n_state   = S_INS_RD;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_MOVE_DIV: if (div_done) n_state = S_PREP;
            S_PREP: begin
                if (r_count == '0) begin
                    n_state = S_OUT;
                end else if (r_len != '0 && r_pos > r_len) begin
                    div_start   = 1'b1;
                    div_req.dvd = DVD_W'(r_pos - 1'b1);
                    n_state     = S_RED_DIV;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_RED_DIV: if (div_done) n_state = S_SRD;
            S_SRD: begin
                ram_re  = 1'b1;
                n_state = S_SCHK;
            end
            S_SCHK: n_state = (rd_lt && !rd_last) ? S_SRD : S_FRAC;
            S_FRAC: begin
                if (frac_pos && !frac_sat) begin
                    div_start = 1'b1;
                    div_req   = '{rem0: frac_n, dvd: '0, divisor: frac_d,
                                  steps: STEP_W'(FRAC_W)};
                    n_state   = S_FDIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_FDIV: if (div_done) n_state = S_MUL;
            S_MUL: n_state = S_OUT;
            S_OUT: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_loop      <= 1'b0;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ANIM_LENGTH: r_len  <= i_cfg_data;
                    CFG_LOOP_ENABLE: r_loop <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end
            if (in_fire && !move_same
                && (t_cmd'(i_cmd) == CMD_SET || t_cmd'(i_cmd) == CMD_ADD)) begin
                if (!r_loop) begin
                    r_pos <= clamp_v;
                end else if (r_len == '0) begin
                    r_pos <= '0;
                end
            end
            if (r_state == S_MOVE_DIV && div_done) begin
                r_pos <= (r_neg && div_rem != '0) ? r_len - div_rem[LEN_W-1:0]
                                                  : div_rem[LEN_W-1:0];
            end
            if ((r_state == S_INS_RD && r_idx == '0)
                || (r_state == S_INS_CHK && !(rd_t > r_arg))) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_arg    <= i_time_arg;
                    r_kval   <= i_key_value;
                    r_neg    <= move_neg;
                    r_idx    <= r_count;
                    r_status <= (t_cmd'(i_cmd) == CMD_INSERT && is_full) ? ST_FULL : ST_OK;
                end
            end
            S_INS_CHK: if (rd_t > r_arg) r_idx <= idx_m1;
            S_PREP: begin
                r_t   <= r_pos;
                r_idx <= '0;
                if (r_count == '0) begin
                    r_status <= ST_EMPTY;
                    r_v1     <= '0;
                    r_prod   <= '0;
                    r_frac   <= '0;
                    r_lower  <= '0;
                end
            end
            S_RED_DIV: if (div_done) r_t <= div_rem[LEN_W-1:0] + 1'b1;
            S_SCHK: begin
                if (r_idx == '0) begin
                    r_first_t <= rd_t;
                    r_first_v <= rd_v;
                end
                if (rd_lt && !rd_last) begin
                    r_prev_t <= rd_t;
                    r_prev_v <= rd_v;
                    r_idx    <= idx_p1;
                end else if (rd_lt) begin
                    // Past the last key: the next key is the first one a length on.
                    r_t2    <= len_s + {first_t_sel[TIME_W-1], first_t_sel};
                    r_v2    <= first_v_sel;
                    r_lower <= r_idx[AW-1:0];
                    r_t1    <= rd_t;
                    r_v1    <= rd_v;
                end else begin
                    r_t2 <= rd_t_s;
                    r_v2 <= rd_v;
                    if (r_idx != '0 && t_s < rd_t_s) begin
                        r_lower <= idx_m1[AW-1:0];
                        r_t1    <= r_prev_t;
                        r_v1    <= r_prev_v;
                    end else begin
                        r_lower <= r_idx[AW-1:0];
                        r_t1    <= rd_t;
                        r_v1    <= rd_v;
                    end
                end
            end
            S_FRAC: begin
                if (!frac_pos) begin
                    r_frac <= '0;
                end else if (frac_sat) begin
                    r_frac <= '1;
                end
            end
            S_FDIV: if (div_done) r_frac <= div_quo;
            S_MUL: r_prod <= diff_v * $signed({1'b0, r_frac});
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_o_time   <= r_pos;
                    r_o_value  <= sat_v;
                    r_o_frac   <= r_frac;
                    r_o_lower  <= lower_wide[LOWER_W-1:0];
                    r_o_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready     = r_state == S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_time_now     = r_o_time;
    assign o_interp_value = r_o_value;
    assign o_fraction     = r_o_frac;
    assign o_lower_index  = r_o_lower;
    assign o_status       = r_o_status;

endmodule

// ----- sv/kla_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear animator checker
// Port-level properties of the animator, bound to the top level.
// ---------------------------------------------------------------------------
`include "keyframe_linear_animator_macros.svh"

module kla_checker
    import kla_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [0:0]          i_cfg_index,
    input logic [LEN_W-1:0]    i_cfg_data,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic [1:0]          i_cmd,
    input logic [TIME_W-1:0]   i_time_arg,
    input logic [TIME_W-1:0]   i_key_value,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [LEN_W-1:0]    o_time_now,
    input logic [TIME_W-1:0]   o_interp_value,
    input logic [FRAC_W-1:0]   o_fraction,
    input logic [LOWER_W-1:0]  o_lower_index,
    input logic [1:0]          o_status
);

    // A stalled result holds.
    `KLA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_interp_value) && $stable(o_time_now), "stalled result changed")

    // Reset leaves no result pending.
    `KLA_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // An empty table reports nothing but the position.
    `KLA_ASSERT(a_empty_zero, o_out_valid && o_status == ST_EMPTY |-> o_fraction == '0 && o_interp_value == '0 && o_lower_index == '0, "empty table result not cleared")

    // Items are handled one at a time.
    `KLA_ASSERT(a_one_item, i_in_valid && o_in_ready |=> !o_in_ready, "second item taken while busy")

endmodule

bind keyframe_linear_animator kla_checker u_kla_checker (.*);

// ----- verif/keyframe_linear_animator_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear animator checker
// Watches the configuration port and both channels, predicts each result
// from its own copy of the keyframe table, and compares it field by field.
// ---------------------------------------------------------------------------
module keyframe_linear_animator_checker
    import kla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [LEN_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [TIME_W-1:0]  i_time_arg,
    input  logic [TIME_W-1:0]  i_key_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [LEN_W-1:0]   i_time_now,
    input  logic [TIME_W-1:0]  i_interp_value,
    input  logic [FRAC_W-1:0]  i_fraction,
    input  logic [LOWER_W-1:0] i_lower_index,
    input  logic [1:0]         i_status,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct packed {
        logic [LEN_W-1:0]   time_now;
        logic [TIME_W-1:0]  interp_value;
        logic [FRAC_W-1:0]  fraction;
        logic [LOWER_W-1:0] lower_index;
        logic [1:0]         status;
    } t_anim_result;

    longint       key_t[MAX_KEYS_DEF];
    longint       key_v[MAX_KEYS_DEF];
    int           n_keys;
    longint       position;
    longint       length_q;
    bit           looping;
    t_anim_result expected_frames[$];

    function automatic void move_position(longint target);
        longint v;
        v = target;
        if (v == position) return;
        if (looping) begin
            if (length_q == 0) begin
                v = 0;
            end else begin
                v = v % length_q;
                if (v < 0) v += length_q;
            end
        end else if (v < 0) begin
            v = 0;
        end else if (v > length_q) begin
            v = length_q;
        end
        position = v;
    endfunction

    function automatic t_anim_result animate(t_cmd cmd, logic [31:0] targ, logic [31:0] kv);
        t_anim_result r;
        longint arg, t, t1, t2, v1, v2, d, m, q, value;
        int p, i;
        r = '0;
        arg = longint'($signed(targ));
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (n_keys >= MAX_KEYS_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    p = 0;
                    while (p < n_keys && key_t[p] <= arg) p++;
                    for (i = n_keys; i > p; i--) begin
                        key_t[i] = key_t[i-1];
                        key_v[i] = key_v[i-1];
                    end
                    key_t[p] = arg;
                    key_v[p] = longint'($signed(kv));
                    n_keys++;
                end
            end
            CMD_SET: move_position(arg);
            CMD_ADD: move_position(position + arg);
            default: ;
        endcase
        if (n_keys == 0) begin
            r.status = ST_EMPTY;
        end else begin
            t = position;
            // The search folds a position above the length back into (0, length].
            if (length_q > 0 && t > length_q) t = (t - 1) % length_q + 1;
            i = 0;
            while (i < n_keys && key_t[i] < t) i++;
            if (i == n_keys) begin
                t2 = length_q + key_t[0];
                v2 = key_v[0];
                i = n_keys - 1;
            end else begin
                t2 = key_t[i];
                v2 = key_v[i];
                if (i != 0 && t < key_t[i]) i--;
            end
            t1 = key_t[i];
            v1 = key_v[i];
            d = t2 - t1;
            m = t - t1;
            q = 0;
            if (d > 0 && m > 0) begin
                q = (m <<< 16) / d;
                if (q > 65535) q = 65535;
            end
            if (q == 0) begin
                value = v1;
            end else begin
                value = v1 + (((v2 - v1) * q) >>> 16);
                if (value > 64'sh7fffffff) value = 64'sh7fffffff;
                if (value < -64'sh80000000) value = -64'sh80000000;
            end
            r.interp_value = value[31:0];
            r.fraction     = q[15:0];
            r.lower_index  = i[3:0];
        end
        r.time_now = position[30:0];
        return r;
    endfunction

    function automatic int field_ok(string name, longint exp_v, longint act_v);
        if (exp_v == act_v) return 1;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_anim_result exp_r;
        int ok;
        if (!i_rst_n) begin
            n_keys   = 0;
            position = 0;
            length_q = 0;
            looping  = 0;
            expected_frames.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_ANIM_LENGTH) length_q = longint'(i_cfg_data);
                else looping = i_cfg_data[0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %0h", $time,
                             {i_time_now, i_interp_value, i_fraction, i_lower_index, i_status});
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_frames.pop_front();
                    ok = field_ok("time_now", exp_r.time_now, i_time_now)
                       & field_ok("interp_value", exp_r.interp_value, i_interp_value)
                       & field_ok("fraction", exp_r.fraction, i_fraction)
                       & field_ok("lower_index", exp_r.lower_index, i_lower_index)
                       & field_ok("status", exp_r.status, i_status);
                    if (!ok) o_fail_count <= o_fail_count + 1;
                end
            end
            if (i_in_valid && i_in_ready)
                expected_frames.push_back(animate(t_cmd'(i_cmd), i_time_arg, i_key_value));
            o_pending <= expected_frames.size();
        end
    end

endmodule

// ----- verif/keyframe_linear_animator_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe linear animator testbench
// Directed keyframe, clamp and wrap cases, then random phases of commands
// under several length and loop settings, with random gaps on both channels.
// ---------------------------------------------------------------------------
module keyframe_linear_animator_test;
    import kla_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 200;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [0:0]         i_cfg_index = CFG_ANIM_LENGTH;
    logic [LEN_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 0;
    logic               o_in_ready;
    logic [1:0]         i_cmd = CMD_NONE;
    logic [TIME_W-1:0]  i_time_arg = '0;
    logic [TIME_W-1:0]  i_key_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 0;
    logic [LEN_W-1:0]   o_time_now;
    logic [TIME_W-1:0]  o_interp_value;
    logic [FRAC_W-1:0]  o_fraction;
    logic [LOWER_W-1:0] o_lower_index;
    logic [1:0]         o_status;
    int                 pending;
    int                 fail_count;
    int                 cycles = 0;
    bit                 gaps_on = 0;
    longint             cur_length = 0;

    always #5 i_clk = ~i_clk;

    keyframe_linear_animator dut (.*);

    keyframe_linear_animator_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_cmd, .i_time_arg, .i_key_value,
        .i_out_valid(o_out_valid), .i_out_ready, .i_time_now(o_time_now),
        .i_interp_value(o_interp_value), .i_fraction(o_fraction),
        .i_lower_index(o_lower_index), .i_status(o_status),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: a random stall before each transfer.
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                i_out_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_frame(t_cmd cmd, logic [31:0] targ, logic [31:0] kv);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_cmd       <= cmd;
        i_time_arg  <= targ;
        i_key_value <= kv;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits for every result and for the block to fall idle, then writes.
    task automatic set_anim(longint len, bit loop_bit);
        i_in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_index <= CFG_ANIM_LENGTH;
        i_cfg_data  <= len[30:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_LOOP_ENABLE;
        i_cfg_data  <= {30'd0, loop_bit};
        @(posedge i_clk);
        i_cfg_we <= 0;
        cur_length = len;
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return $urandom_range(0, 64);
            default: return 32'($urandom_range(0, 32'h7fffffff) % (cur_length + 2));
        endcase
    endfunction

    initial begin
        int     r;
        t_cmd   cmd;
        longint len;
        logic [31:0] targ;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Empty table, zero length, clamping.
        send_frame(CMD_SET, 32'hffff_0000, 32'h0);
        send_frame(CMD_ADD, 32'h0001_0000, 32'h0);
        send_frame(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff);
        set_anim(64'h000a_0000, 0);
        send_frame(CMD_INSERT, 32'h0000_0000, 32'h0000_0064);
        send_frame(CMD_INSERT, 32'h0005_0000, 32'hffff_ff38);
        send_frame(CMD_INSERT, 32'h0005_0000, 32'h0000_0007);   // equal time
        send_frame(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_frame(CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_frame(CMD_SET, 32'h0003_0000, 32'h0);
        send_frame(CMD_SET, 32'h0005_0000, 32'h0);
        send_frame(CMD_SET, 32'h7fff_ffff, 32'h0);             // clamped to length
        send_frame(CMD_SET, 32'h7fff_ffff, 32'h0);             // clamp again
        send_frame(CMD_SET, 32'h8000_0000, 32'h0);             // clamped to zero
        send_frame(CMD_ADD, 32'h0008_8000, 32'h0);
        send_frame(CMD_ADD, 32'h0000_0000, 32'h0);             // unchanged
        send_frame(CMD_NONE, 32'h1234_5678, 32'h0);
        // Length shrinks below the position: the search folds it back.
        set_anim(64'h0003_0000, 0);
        send_frame(CMD_NONE, 32'h0, 32'h0);
        set_anim(64'h7fff_ffff, 1);
        send_frame(CMD_SET, 32'hffff_fff0, 32'h0);
        send_frame(CMD_ADD, 32'h7fff_ffff, 32'h0);
        set_anim(0, 1);                                          // loop, zero length
        send_frame(CMD_SET, 32'h0004_0000, 32'h0);
        send_frame(CMD_ADD, 32'h0000_0001, 32'h0);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       len = 64'h7fff_ffff;
                1:       len = 0;
                2, 3, 4: len = $urandom_range(1, 32'h0020_0000);
                default: len = $urandom_range(0, 32'h7fff_ffff);
            endcase
            set_anim(len, phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 200; k++) begin
                r = $urandom_range(0, 99);
                if (r < 15)      cmd = CMD_INSERT;
                else if (r < 50) cmd = CMD_SET;
                else if (r < 95) cmd = CMD_ADD;
                else             cmd = CMD_NONE;
                if (cmd == CMD_ADD && $urandom_range(0, 3) != 0)
                    targ = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                else
                    targ = pick_time();
                send_frame(cmd, targ, $urandom());
            end
        end

        i_in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- keyframe_linear_animator.f -----
+incdir+sv
sv/kla_pkg.sv
sv/kla_key_ram.sv
sv/kla_divider.sv
sv/keyframe_linear_animator.sv
sv/kla_checker.sv
verif/keyframe_linear_animator_checker.sv
verif/keyframe_linear_animator_test.sv
